[design/two_axis_sine_trajectory_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-axis sine trajectory generator
// Concurrent checks on the clock with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_SINE_TRAJECTORY_DEFINES_SVH
`define TWO_AXIS_SINE_TRAJECTORY_DEFINES_SVH
`ifndef SYNTH
`define TAST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TAST_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TAST_ASSERT(lbl, clk, rst, prop, msg)
`define TAST_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[design/tast_pkg.sv]
// ----------------------------------------------------------------------------
// tast_pkg
// Shared constants, types and helpers of the sine trajectory generator.
// ----------------------------------------------------------------------------
`default_nettype none
package tast_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int COUNT_WIDTH_DEF     = 16;
   localparam int CORDIC_STEPS_DEF    = 16;

   localparam int DVD_W   = 48;
   localparam int DIV_W   = 16;
   localparam int STEP_W  = 6;
   localparam int CW      = 34;
   localparam int TAB_LEN = 24;
   localparam int IX_W    = 5;

   localparam int STEP_LINE   = 6;
   localparam int STEP_CIRCLE = 4;
   localparam int PHASE_STEPS = 32;
   localparam int DEG_TURN    = 360;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_RADIUS = 2'd1;
   localparam logic [1:0] CSR_ANGLE  = 2'd2;
   localparam logic [1:0] CSR_PERIOD = 2'd3;

   localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURN [TAB_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cor_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // round half up, then arithmetic shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned s);
      logic signed [63:0] h;
      h = 64'sd1 <<< (s - 1);
      return (v + h) >>> s;
   endfunction

   function automatic logic [15:0] sat16(input logic signed [63:0] v, input int lim);
      logic signed [63:0] l;
      logic signed [63:0] r;
      l = 64'(lim);
      r = v;
      if (r > l) r = l;
      if (r < -l) r = -l;
      return r[15:0];
   endfunction

endpackage
`default_nettype wire

[design/two_axis_sine_trajectory.sv]
// Flow: a new tick is taken only in idle, once the last result has gone to the
// output register; the restoring divider (one bit a cycle) and the CORDIC unit
// (one step a cycle) set the pace, and the multiplier is shared.
// Reset: synchronous; registers return to mode 0, radius 10, angle 40,
// period 512, both time counters to zero.
// ----------------------------------------------------------------------------
// two_axis_sine_trajectory
// Line and circle swing references for pitch and yaw from a phase counter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_axis_sine_trajectory_defines.svh"
module two_axis_sine_trajectory import tast_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_loop_odd,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_pitch_ref,
   output logic signed [15:0]      rsp_yaw_ref,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   localparam int VW   = COUNT_WIDTH + 1;
   localparam int SH   = 46 - ANGLE_FRAC_BITS;
   localparam int LIM0 = 80 << ANGLE_FRAC_BITS;
   localparam int LIM  = (LIM0 > 32767) ? 32767 : LIM0;
   localparam logic signed [63:0] ONE_DEG_Q46 = 64'sd1 <<< 46;
   localparam logic signed [CW-1:0] Q30_HALF_TURN = 34'sd2147483648;
   localparam logic signed [CW-1:0] Q30_QUARTER   = 34'sd1073741824;

   typedef enum logic [3:0] {
      S_IDLE, S_MOD, S_PHASE, S_ANG, S_AMP, S_SINP, S_SINA,
      S_MUL_AX, S_RND_AX, S_MUL_AY, S_RND_AY, S_MUL_P, S_RND_P,
      S_MUL_Y, S_RND_Y, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic             mode_ff;
   logic [5:0]       radius_ff;
   logic [7:0]       angle_ff;
   logic [15:0]      period_ff;
   logic [15:0]      period_eff;

   logic [COUNT_WIDTH-1:0] line_cnt_ff, circle_cnt_ff, act_cnt, count_now;
   logic [VW-1:0]          adv_val;

   logic                   odd_ff;
   logic [31:0]            phase_ff, ang_ff, turn_sel;
   logic [31:0]            ang_tab [256];
   logic signed [24:0]     amp_ff, ax_ff, ay_ff, mul_a;
   logic signed [32:0]     cp_ff, sp_ff, ca_ff, sa_ff, mul_b;
   logic signed [57:0]     mul_p;
   logic signed [63:0]     prod_ff, prod_in;
   logic                   neg_ff, neg_in;
   logic [15:0]            pitch_ff, yaw_ff;
   logic                   rsp_valid_ff;
   logic [15:0]            rsp_pitch_ff, rsp_yaw_ff;

   div_cmd_type            div_cmd;
   unit_sts_type           div_sts;
   logic [DIV_W-1:0]       div_rem_init, div_divisor, div_rem;
   logic [DVD_W-1:0]       div_dvd_init, div_quot;
   logic                   div_start;

   cor_cmd_type            cor_cmd;
   unit_sts_type           cor_sts;
   logic                   cor_start, cor_vec;
   logic signed [CW-1:0]   cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
   logic signed [CW-1:0]   zt, zr, zc;
   logic [44:0]            amp_wide;
   logic signed [24:0]     amp_in;

   assign period_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign act_cnt    = mode_ff ? circle_cnt_ff : line_cnt_ff;
   assign adv_val    = req_loop_odd
                       ? ({1'b0, act_cnt} + VW'(mode_ff ? STEP_CIRCLE : STEP_LINE))
                       : {1'b0, act_cnt};
   assign count_now  = COUNT_WIDTH'(div_rem);

   // line direction as a turn fraction, rounded to nearest
   for (genvar g = 0; g < 256; g++) begin : g_ang_tab
      localparam logic [63:0] ANG_NUM = (64'(g) << 32) + 64'd180;
      assign ang_tab[g] = 32'(ANG_NUM / 64'(DEG_TURN));
   end

   // divider operands follow the step that launches it
   always_comb begin
      div_divisor   = period_eff;
      div_cmd.start = div_start;
      case (state_ff)
         S_IDLE: begin
            div_cmd.steps = STEP_W'(VW);
            div_rem_init  = '0;
            div_dvd_init  = DVD_W'(adv_val) << (DVD_W - VW);
         end
         default: begin
            div_cmd.steps = STEP_W'(PHASE_STEPS);
            div_rem_init  = DIV_W'(count_now);
            div_dvd_init  = '0;
         end
      endcase
   end

   // fold the turn into the right half-plane, flip the result back later
   assign turn_sel = (state_ff == S_SINP) ? ang_ff : phase_ff;
   assign zt       = CW'(signed'(turn_sel));
   always_comb begin
      zr     = zt;
      neg_in = 1'b0;
      if (zt > Q30_QUARTER) begin
         zr     = zt - Q30_HALF_TURN;
         neg_in = 1'b1;
      end else if (zt < -Q30_QUARTER) begin
         zr     = zt + Q30_HALF_TURN;
         neg_in = 1'b1;
      end
   end

   assign cor_vec = (state_ff == S_PHASE) || (state_ff == S_ANG);
   assign cor_cmd = '{start: cor_start, vectoring: cor_vec};
   assign cor_x0  = cor_vec ? CW'(34'sd15 <<< 24) : INV_GAIN;
   assign cor_y0  = cor_vec ? signed'(CW'({radius_ff, 24'd0})) : '0;
   assign cor_z0  = cor_vec ? '0 : zr;

   // amplitude in degrees Q16, negative angle clamped to zero
   assign zc       = cor_z[CW-1] ? '0 : cor_z;
   assign amp_wide = 45'(zc) * 45'd360 + 45'd32768;
   assign amp_in   = signed'(25'(amp_wide >> 16));

   always_comb begin
      case (state_ff)
         S_MUL_AX: begin
            mul_a = amp_ff;
            mul_b = ca_ff;
         end
         S_MUL_AY: begin
            mul_a = amp_ff;
            mul_b = sa_ff;
         end
         S_MUL_P: begin
            mul_a = mode_ff ? amp_ff : ax_ff;
            mul_b = sp_ff;
         end
         default: begin
            mul_a = mode_ff ? amp_ff : ay_ff;
            mul_b = mode_ff ? cp_ff : sp_ff;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = 64'(mul_p)
                    - ((mode_ff && state_ff == S_MUL_Y) ? ONE_DEG_Q46 : 64'sd0);

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      cor_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               div_start = 1'b1;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            if (div_sts.done) begin
               div_start = 1'b1;
               state_in  = S_PHASE;
            end
         end
         S_PHASE: begin
            if (div_sts.done) begin
               if (mode_ff) begin
                  cor_start = 1'b1;
                  state_in  = S_AMP;
               end else begin
                  state_in  = S_ANG;
               end
            end
         end
         S_ANG: begin
            cor_start = 1'b1;
            state_in  = S_AMP;
         end
         S_AMP: begin
            if (cor_sts.done) begin
               cor_start = 1'b1;
               state_in  = S_SINP;
            end
         end
         S_SINP: begin
            if (cor_sts.done) begin
               if (mode_ff) begin
                  state_in = S_MUL_P;
               end else begin
                  cor_start = 1'b1;
                  state_in  = S_SINA;
               end
            end
         end
         S_SINA:   if (cor_sts.done) state_in = S_MUL_AX;
         S_MUL_AX: state_in = S_RND_AX;
         S_RND_AX: state_in = S_MUL_AY;
         S_MUL_AY: state_in = S_RND_AY;
         S_RND_AY: state_in = S_MUL_P;
         S_MUL_P:  state_in = S_RND_P;
         S_RND_P:  state_in = S_MUL_Y;
         S_MUL_Y:  state_in = S_RND_Y;
         S_RND_Y:  state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= 1'b0;
         radius_ff     <= 6'd10;
         angle_ff      <= 8'd40;
         period_ff     <= 16'd512;
         line_cnt_ff   <= '0;
         circle_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE:   mode_ff   <= csr_wdata[0];
               CSR_RADIUS: radius_ff <= csr_wdata[5:0];
               CSR_ANGLE:  angle_ff  <= csr_wdata[7:0];
               CSR_PERIOD: period_ff <= csr_wdata;
               default:    ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: odd_ff <= req_loop_odd;
            S_MOD: begin
               // advance the active counter only on odd ticks
               if (div_sts.done && odd_ff) begin
                  if (mode_ff) circle_cnt_ff <= count_now;
                  else         line_cnt_ff   <= count_now;
               end
            end
            S_PHASE:  if (div_sts.done) phase_ff <= div_quot[31:0];
            S_ANG:    ang_ff <= ang_tab[angle_ff];
            S_AMP:    if (cor_sts.done) amp_ff <= amp_in;
            S_SINP: begin
               if (cor_sts.done) begin
                  cp_ff <= 33'(neg_ff ? -cor_x : cor_x);
                  sp_ff <= 33'(neg_ff ? -cor_y : cor_y);
               end
            end
            S_SINA: begin
               if (cor_sts.done) begin
                  ca_ff <= 33'(neg_ff ? -cor_x : cor_x);
                  sa_ff <= 33'(neg_ff ? -cor_y : cor_y);
               end
            end
            S_MUL_AX, S_MUL_AY, S_MUL_P, S_MUL_Y: prod_ff <= prod_in;
            S_RND_AX: ax_ff    <= 25'(rnd_shift(prod_ff, 30));
            S_RND_AY: ay_ff    <= 25'(rnd_shift(prod_ff, 30));
            S_RND_P:  pitch_ff <= sat16(rnd_shift(prod_ff, SH), LIM);
            S_RND_Y:  yaw_ff   <= sat16(rnd_shift(prod_ff, SH), LIM);
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pitch_ff <= pitch_ff;
                  rsp_yaw_ff   <= yaw_ff;
               end
            end
            default: ;
         endcase
         if (cor_start && !cor_vec) neg_ff <= neg_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pitch_ref = signed'(rsp_pitch_ff);
   assign rsp_yaw_ref   = signed'(rsp_yaw_ff);

   tast_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .rem_init (div_rem_init),
      .dvd_init (div_dvd_init),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   tast_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cor_cmd),
      .x0    (cor_x0),
      .y0    (cor_y0),
      .z0    (cor_z0),
      .sts   (cor_sts),
      .x     (cor_x),
      .y     (cor_y),
      .z     (cor_z)
   );

   `TAST_ASSERT(a_cnt_hold, clock, reset, !(state_ff == S_MOD && div_sts.done && odd_ff) |=> ($stable(line_cnt_ff) && $stable(circle_cnt_ff)), "time counter moved outside an odd tick update")
   `TAST_ASSERT(a_cnt_wrap, clock, reset, (state_ff == S_MOD && div_sts.done && odd_ff) |=> (32'(act_cnt) < 32'(period_eff)), "time counter not below period after advance")
   `TAST_ASSERT_NEVER(a_div_restart, clock, reset, div_cmd.start && div_sts.busy, "divider restarted while busy")
   `TAST_ASSERT_NEVER(a_cor_restart, clock, reset, cor_cmd.start && cor_sts.busy, "cordic restarted while busy")

endmodule
`default_nettype wire

[design/tast_div.sv]
// ----------------------------------------------------------------------------
// tast_div
// Restoring divider, one quotient bit per cycle, preset remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module tast_div import tast_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire div_cmd_type      cmd,
   input  wire logic [DIV_W-1:0] rem_init,
   input  wire logic [DVD_W-1:0] dvd_init,
   input  wire logic [DIV_W-1:0] divisor,
   output unit_sts_type          sts,
   output logic [DVD_W-1:0]      quot,
   output logic [DIV_W-1:0]      rem
);

   logic [DIV_W-1:0]  rem_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            rem_ff  <= rem_init;
            dvd_ff  <= dvd_init;
            cnt_ff  <= cmd.steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = dvd_ff;
   assign rem      = rem_ff;

endmodule
`default_nettype wire

[design/tast_cordic.sv]
// ----------------------------------------------------------------------------
// tast_cordic
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
`default_nettype none
module tast_cordic import tast_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cor_cmd_type          cmd,
   input  wire logic signed [CW-1:0] x0,
   input  wire logic signed [CW-1:0] y0,
   input  wire logic signed [CW-1:0] z0,
   output unit_sts_type              sts,
   output logic signed [CW-1:0]      x,
   output logic signed [CW-1:0]      y,
   output logic signed [CW-1:0]      z
);

   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic [IX_W-1:0]      ix_ff;
   logic                 vec_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic signed [CW-1:0] xs, ys, at;
   logic                 sigma;

   assign xs    = x_ff >>> ix_ff;
   assign ys    = y_ff >>> ix_ff;
   assign at    = signed'(CW'(ATAN_TURN[ix_ff]));
   // rotate towards z = 0, or drive y towards zero when vectoring
   assign sigma = vec_ff ? (y_ff <= 0) : (z_ff >= 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            x_ff    <= x0;
            y_ff    <= y0;
            z_ff    <= z0;
            vec_ff  <= cmd.vectoring;
            ix_ff   <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (sigma) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            ix_ff <= ix_ff + 1'b1;
            if (ix_ff == IX_W'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign x        = x_ff;
   assign y        = y_ff;
   assign z        = z_ff;

endmodule
`default_nettype wire

[test/two_axis_sine_trajectory_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_axis_sine_trajectory_tb
// Drives control ticks through the line and circle swing generator under
// random handshake stalls and a range of register settings, predicts every
// pitch and yaw reference in fixed point and checks each result in order.
// ----------------------------------------------------------------------------
module two_axis_sine_trajectory_tb;
   import tast_pkg::*;

   localparam int FRAC     = 8;
   localparam int STEPS    = 16;
   localparam int OUT_LIM  = 80 << FRAC;
   localparam int SETTLE   = 200;
   localparam int WD_LIMIT = 5000;

   typedef struct {
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } swing_ref_type;

   class swing_scoreboard;
      bit            mode;
      logic [5:0]    radius;
      logic [7:0]    angle;
      logic [15:0]   period;
      logic [15:0]   line_cnt;
      logic [15:0]   circle_cnt;
      swing_ref_type refs_due[$];
      int            errors;

      function void clear();
         mode = 0; radius = 10; angle = 40; period = 512;
         line_cnt = 0; circle_cnt = 0;
         refs_due.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_MODE:   mode = val[0];
            CSR_RADIUS: radius = val[5:0];
            CSR_ANGLE:  angle = val[7:0];
            CSR_PERIOD: period = val;
            default: ;
         endcase
      endfunction

      // rotation mode CORDIC, Q30 cos and sin of a turn fraction
      function void turn_cos_sin(logic [31:0] turn, output longint c, output longint s);
         longint z, x, y, nx;
         bit     neg;
         z = longint'($signed(turn));
         x = 652032874; y = 0; neg = 0;
         if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; neg = 1;
         end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; neg = 1;
         end
         for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TURN[i]);
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TURN[i]);
            end
            x = nx;
         end
         c = neg ? -x : x;
         s = neg ? -y : y;
      endfunction

      // tilt amplitude atan(radius/15) in degrees, Q16
      function longint tilt_amp_q16();
         longint x, y, z, nx;
         x = longint'(15) << 24; y = longint'(radius) << 24; z = 0;
         for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
               nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TURN[i]);
            end else begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TURN[i]);
            end
            x = nx;
         end
         if (z < 0) z = 0;
         return (z * 360 + 32768) >>> 16;
      endfunction

      function longint rnd(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function logic signed [15:0] clamp(longint v);
         if (v > OUT_LIM) v = OUT_LIM;
         if (v < -OUT_LIM) v = -OUT_LIM;
         return v[15:0];
      endfunction

      function void note_tick(bit odd);
         longint unsigned per, cnt, turn, at;
         longint amp, cp, sp, ca, sa, ax, ay, pitch, yaw;
         int sh;
         swing_ref_type r;
         sh = 46 - FRAC;
         per = (period == 0) ? 1 : period;
         if (odd) begin
            if (mode) circle_cnt = 16'((circle_cnt + 64'd4) % per);
            else      line_cnt   = 16'((line_cnt + 64'd6) % per);
         end
         cnt = (mode ? circle_cnt : line_cnt) % per;
         turn = (cnt << 32) / per;
         amp = tilt_amp_q16();
         turn_cos_sin(turn[31:0], cp, sp);
         if (mode) begin
            pitch = rnd(amp * sp, sh);
            yaw = rnd(amp * cp - (longint'(1) << 46), sh);
         end else begin
            at = (longint'(angle) * 64'd4294967296 + 180) / 360;
            turn_cos_sin(at[31:0], ca, sa);
            ax = rnd(amp * ca, 30);
            ay = rnd(amp * sa, 30);
            pitch = rnd(ax * sp, sh);
            yaw = rnd(ay * sp, sh);
         end
         r.pitch = clamp(pitch);
         r.yaw = clamp(yaw);
         refs_due.push_back(r);
      endfunction

      function void check_ref(logic signed [15:0] pitch, logic signed [15:0] yaw);
         swing_ref_type r;
         if (refs_due.size() == 0) begin
            $error("unexpected result: pitch_ref %0d yaw_ref %0d", pitch, yaw);
            errors++;
            return;
         end
         r = refs_due.pop_front();
         if (pitch !== r.pitch) begin
            $error("pitch_ref: expected %0d, actual %0d", r.pitch, pitch);
            errors++;
         end
         if (yaw !== r.yaw) begin
            $error("yaw_ref: expected %0d, actual %0d", r.yaw, yaw);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_loop_odd;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_pitch_ref;
   logic signed [15:0] rsp_yaw_ref;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   swing_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   two_axis_sine_trajectory uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_loop_odd(req_loop_odd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pitch_ref(rsp_pitch_ref), .rsp_yaw_ref(rsp_yaw_ref),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check results and watch for a stalled run
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_ref(rsp_pitch_ref, rsp_yaw_ref);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WD_LIMIT) begin
            $display("two_axis_sine_trajectory_tb: FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_tick(bit odd);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_loop_odd <= odd;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(odd);
   endtask

   // hold the sender until every result is back, then let the block go idle
   task automatic drain();
      req_valid <= 0;
      while (sb.refs_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(bit mode, int radius, int angle, int period);
      logic [15:0] vals[4];
      vals = '{16'(mode), 16'(radius), 16'(angle), 16'(period)};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(2'(i), vals[i]);
      end
      csr_we <= 0;
   endtask

   task automatic run_phase(bit mode, int radius, int angle, int period,
                            int n, logic [31:0] odd_pat, bit rnd_ticks);
      drain();
      configure(mode, radius, angle, period);
      for (int i = 0; i < n; i++)
         send_tick(rnd_ticks ? ($urandom_range(99) < 75) : odd_pat[i]);
   endtask

   initial begin
      int per;
      sb = new();
      sb.clear();
      send_idle_pct = 38;
      recv_idle_pct = 57;
      reset = 1;
      req_valid = 0;
      req_loop_odd = 0;
      rsp_ready = 0;
      csr_we = 0;
      csr_index = CSR_MODE;
      csr_wdata = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, zero radius and period, extremes, shrink
      for (int i = 0; i < 3; i++) send_tick(i != 0);
      run_phase(0, 0, 0, 0, 2, 32'b11, 0);
      run_phase(0, 63, 255, 65535, 3, 32'b101, 0);
      run_phase(0, 60, 90, 7, 3, 32'b111, 0);
      run_phase(1, 1, 180, 65535, 3, 32'b011, 0);
      run_phase(1, 60, 0, 5, 3, 32'b111, 0);
      run_phase(1, 63, 40, 3, 3, 32'b101, 0);
      run_phase(0, 30, 180, 2, 3, 32'b110, 0);

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 4) begin
            send_idle_pct = 57; recv_idle_pct = 38;
         end else if (ph == 8) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         case ($urandom_range(9))
            0:       per = 0;
            1:       per = 65535;
            2:       per = $urandom_range(65535);
            default: per = $urandom_range(1, 300);
         endcase
         run_phase($urandom_range(1), (ph % 5 == 0) ? 63 * (ph % 2) : $urandom_range(63),
                   $urandom_range(255), per, 100, 0, 1);
      end
      drain();

      if (sb.errors == 0 && sb.refs_due.size() == 0) begin
         $display("two_axis_sine_trajectory_tb: PASS");
      end else begin
         $display("two_axis_sine_trajectory_tb: FAIL");
      end
      $finish;
   end

endmodule
